// ----- design/btss_pkg.sv -----
// Package for the bilinear texel sampler: transaction structs, config layout,
// codes and default parameter values. No dependencies.
package btss_pkg;

  localparam int MAX_WIDTH_DEF       = 128;
  localparam int MAX_HEIGHT_DEF      = 128;
  localparam int MAX_CHANNELS_DEF    = 4;
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int PIXEL_BITS_DEF      = 16;
  localparam int COORD_BITS          = 24;
  localparam int VALUE_BITS          = 16;
  localparam int CFG_DATA_BITS       = 16;
  localparam int CFG_IDX_BITS        = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS, CFG_MODE, CFG_FILL
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BND_FILL, BND_CLAMP, BND_WRAP, BND_FILL_ALL
  } bnd_mode_e;

  typedef enum logic {
    KIND_WRITE, KIND_SAMPLE
  } kind_e;

  typedef enum logic [1:0] {
    F_IDLE, F_DIV, F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_RD0, B_RD1, B_RD2, B_RD3, B_CAP, B_TOP, B_BOT, B_SUM, B_RND
  } back_state_e;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic [1:0]                   channel;
    logic [6:0]                   write_x;
    logic [6:0]                   write_y;
    logic signed [VALUE_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         channel_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0]                   img_cols;
    logic [7:0]                   img_rows;
    logic [2:0]                   channel_count;
    logic [1:0]                   boundary_mode;
    logic signed [VALUE_BITS-1:0] border_val;
  } cfg_t;

endpackage

// ----- design/btss_fifo.sv -----
// Small FIFO between the sampler front and back ends.
// No package dependencies.
module btss_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_q [DEPTH];
  logic [PTW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTW'(DEPTH - 1)) ? '0 : wr_q + PTW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTW'(DEPTH - 1)) ? '0 : rd_q + PTW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// ----- design/btss_front.sv -----
// Front end: accepts transactions, checks channel and bounds, splits the
// coordinates and maps neighbor indices by boundary mode. Uses btss_pkg.
module btss_front import btss_pkg::*; #(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
  parameter int EW              = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  in_item_t      item_i,
  input  cfg_t          cfg_i,
  output logic          push_o,
  output logic [EW-1:0] entry_o,
  input  logic          full_i
);
  localparam int F   = COORD_FRAC_BITS;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW  = COORD_BITS - F;
  localparam int MD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int NM  = $clog2(MD + 1);
  localparam int AW  = (CW + 1 > NM + 1) ? CW + 1 : NM + 1;
  localparam int CTW = $clog2(CW);
  localparam int PB  = PIXEL_BITS;
  localparam logic signed [AW-1:0] ONE_A = AW'(1);
  localparam logic signed [33:0] PIX_HI = 34'sd2 ** (PB - 1) - 34'sd1;
  localparam logic signed [33:0] PIX_LO = -PIX_HI - 34'sd1;

  typedef struct packed {
    logic                  is_write;
    logic                  err;
    logic [CHW-1:0]        chan;
    logic [XW-1:0]         x0;
    logic [XW-1:0]         x1;
    logic [YW-1:0]         y0;
    logic [YW-1:0]         y1;
    logic                  okx0;
    logic                  okx1;
    logic                  oky0;
    logic                  oky1;
    logic [F-1:0]          tx;
    logic [F-1:0]          ty;
    logic signed [PB-1:0]  wval;
  } entry_t;

  front_state_e         state_q, state_d;
  in_item_t             item_q;
  logic                 err_q, err_d;
  logic signed [CW-1:0] x0_q, y0_q;
  logic [CW-1:0]        magx_q, magx_d, magy_q, magy_d;
  logic [NM:0]          remx_q, remx_d, remy_q, remy_d;
  logic [CTW-1:0]       cnt_q, cnt_d;
  logic [NM-1:0]        ew, eh, rx, ry, rx1, ry1;
  logic [NM:0]          mx0, mx1, my0, my1;
  logic signed [CW-1:0] xin, yin;
  logic                 chan_ok, wr_ok;
  entry_t               e;

  function automatic logic [NM-1:0] eff_dim(logic [7:0] v, int mx);
    if (v == 8'd0) return NM'(1);
    if (int'(v) > mx) return NM'(mx);
    return NM'(v);
  endfunction

  function automatic logic [NM:0] rem_step(logic [NM:0] r, logic b, logic [NM-1:0] n);
    logic [NM:0] t;
    t = {r[NM-1:0], b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t;
  endfunction

  function automatic logic [NM-1:0] wrap_fix(logic [NM:0] r, logic neg, logic [NM-1:0] n);
    if (neg && (r != '0)) return n - r[NM-1:0];
    return r[NM-1:0];
  endfunction

  // returns {ok, index}
  function automatic logic [NM:0] map_axis(logic signed [AW-1:0] v, logic [NM-1:0] n,
                                          logic [1:0] mode, logic [NM-1:0] wr);
    logic signed [AW-1:0] ns;
    logic [NM:0]          res;
    ns = AW'(n);
    unique case (bnd_mode_e'(mode))
      BND_FILL:  res = {(v >= 0) && (v < ns), v[NM-1:0]};
      BND_CLAMP: begin
        if (v < 0) res = {1'b1, NM'(0)};
        else if (v >= ns) res = {1'b1, n - NM'(1)};
        else res = {1'b1, v[NM-1:0]};
      end
      BND_WRAP:  res = {1'b1, wr};
      default:   res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [PB-1:0] sat_pix(logic signed [VALUE_BITS-1:0] v);
    logic signed [33:0] t;
    t = 34'(v);
    if (t > PIX_HI) t = PIX_HI;
    if (t < PIX_LO) t = PIX_LO;
    return t[PB-1:0];
  endfunction

  assign ew      = eff_dim(cfg_i.img_cols, MAX_WIDTH);
  assign eh      = eff_dim(cfg_i.img_rows, MAX_HEIGHT);
  assign chan_ok = ({1'b0, item_i.channel} < cfg_i.channel_count) &&
                   (int'(item_i.channel) < MAX_CHANNELS);
  assign wr_ok   = chan_ok && (int'(item_i.write_x) < int'(ew)) &&
                   (int'(item_i.write_y) < int'(eh));
  assign xin     = item_i.coord_x[COORD_BITS-1:F];
  assign yin     = item_i.coord_y[COORD_BITS-1:F];
  assign busy_o  = (state_q != F_IDLE);

  assign rx  = wrap_fix(remx_q, x0_q[CW-1], ew);
  assign ry  = wrap_fix(remy_q, y0_q[CW-1], eh);
  assign rx1 = (rx + NM'(1) == ew) ? '0 : rx + NM'(1);
  assign ry1 = (ry + NM'(1) == eh) ? '0 : ry + NM'(1);
  assign mx0 = map_axis(AW'(x0_q), ew, cfg_i.boundary_mode, rx);
  assign mx1 = map_axis(AW'(x0_q) + ONE_A, ew, cfg_i.boundary_mode, rx1);
  assign my0 = map_axis(AW'(y0_q), eh, cfg_i.boundary_mode, ry);
  assign my1 = map_axis(AW'(y0_q) + ONE_A, eh, cfg_i.boundary_mode, ry1);

  always_comb begin
    e          = '0;
    e.is_write = (item_q.kind == KIND_WRITE);
    e.err      = err_q;
    e.chan     = CHW'(item_q.channel);
    e.tx       = item_q.coord_x[F-1:0];
    e.ty       = item_q.coord_y[F-1:0];
    e.wval     = sat_pix(item_q.write_value);
    if (item_q.kind == KIND_WRITE) begin
      e.x0 = XW'(item_q.write_x);
      e.y0 = YW'(item_q.write_y);
    end else begin
      e.x0   = XW'(mx0[NM-1:0]);
      e.x1   = XW'(mx1[NM-1:0]);
      e.y0   = YW'(my0[NM-1:0]);
      e.y1   = YW'(my1[NM-1:0]);
      e.okx0 = mx0[NM];
      e.okx1 = mx1[NM];
      e.oky0 = my0[NM];
      e.oky1 = my1[NM];
    end
  end
  assign entry_o = EW'(e);

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    magx_d  = magx_q;
    magy_d  = magy_q;
    remx_d  = remx_q;
    remy_d  = remy_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          err_d  = !chan_ok;
          magx_d = xin[CW-1] ? CW'(-xin) : CW'(xin);
          magy_d = yin[CW-1] ? CW'(-yin) : CW'(yin);
          remx_d = '0;
          remy_d = '0;
          cnt_d  = '0;
          if (item_i.kind == KIND_WRITE) begin
            state_d = wr_ok ? F_PUSH : F_IDLE;
          end else begin
            state_d = chan_ok ? F_DIV : F_PUSH;
          end
        end
      end
      F_DIV: begin
        remx_d = rem_step(remx_q, magx_q[CW-1], ew);
        remy_d = rem_step(remy_q, magy_q[CW-1], eh);
        magx_d = magx_q << 1;
        magy_d = magy_q << 1;
        cnt_d  = cnt_q + CTW'(1);
        if (cnt_q == CTW'(CW - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      item_q <= item_i;
      x0_q   <= xin;
      y0_q   <= yin;
    end
    err_q  <= err_d;
    magx_q <= magx_d;
    magy_q <= magy_d;
    remx_q <= remx_d;
    remy_q <= remy_d;
  end
endmodule

// ----- design/btss_back.sv -----
// Back end: owns the image memory, executes pixel writes, fetches the four
// neighbors one per cycle and blends them. Uses btss_pkg.
module btss_back import btss_pkg::*; #(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
  parameter int EW              = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          empty_i,
  input  logic [EW-1:0] entry_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output out_item_t     res_o
);
  localparam int F   = COORD_FRAC_BITS;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PB  = PIXEL_BITS;
  localparam int PW  = (PB > VALUE_BITS) ? PB : VALUE_BITS;
  localparam int TW  = PW + F + 3;
  localparam int SW  = TW + F + 3;
  localparam int MAW = YW + XW + CHW;
  localparam logic [F:0] S_W = {1'b1, {F{1'b0}}};
  localparam logic signed [SW:0] HALF  = (SW + 1)'(1) <<< (2 * F - 1);
  localparam logic signed [SW:0] V_MAX = (SW + 1)'(2 ** (VALUE_BITS - 1) - 1);
  localparam logic signed [SW:0] V_MIN = -V_MAX - (SW + 1)'(1);

  typedef struct packed {
    logic                  is_write;
    logic                  err;
    logic [CHW-1:0]        chan;
    logic [XW-1:0]         x0;
    logic [XW-1:0]         x1;
    logic [YW-1:0]         y0;
    logic [YW-1:0]         y1;
    logic                  okx0;
    logic                  okx1;
    logic                  oky0;
    logic                  oky1;
    logic [F-1:0]          tx;
    logic [F-1:0]          ty;
    logic signed [PB-1:0]  wval;
  } entry_t;

  logic signed [PB-1:0] mem_q [2**MAW];
  logic signed [PB-1:0] rdata_q;
  logic [MAW-1:0]       addr;
  logic                 we;

  back_state_e          state_q, state_d;
  entry_t               head, e_q;
  logic signed [PW-1:0] p_q [4];
  logic signed [PW-1:0] cap, fillv;
  logic                 cap_ok;
  logic [1:0]           cap_idx;
  logic                 cap_en;
  logic signed [TW-1:0] top_q, bot_q, mix_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [SW:0]   rnd;
  logic [F:0]           wx0, wx1, wy0, wy1;
  logic                 res_valid_q, res_valid_d;
  out_item_t            res_q, res_d;

  assign head  = entry_t'(entry_i);
  assign fillv = PW'(cfg_i.border_val);
  assign wx1   = {1'b0, e_q.tx};
  assign wx0   = S_W - wx1;
  assign wy1   = {1'b0, e_q.ty};
  assign wy0   = S_W - wy1;
  assign cap   = cap_ok ? PW'(rdata_q) : fillv;
  assign rnd   = (SW + 1)'(sum_q) + HALF;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    addr        = {e_q.y0, e_q.x0, e_q.chan};
    cap_en      = 1'b0;
    cap_idx     = 2'd0;
    cap_ok      = 1'b0;
    mix_d       = '0;
    sum_d       = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      B_IDLE: begin
        addr = {head.y0, head.x0, head.chan};
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head.is_write) begin
            we = 1'b1;
          end else if (head.err) begin
            res_valid_d = 1'b1;
            res_d       = '{sample_value: '0, channel_error: 1'b1};
          end else begin
            state_d = B_RD0;
          end
        end
      end
      B_RD0: begin
        addr    = {e_q.y0, e_q.x0, e_q.chan};
        state_d = B_RD1;
      end
      B_RD1: begin
        addr    = {e_q.y0, e_q.x1, e_q.chan};
        cap_en  = 1'b1;
        cap_idx = 2'd0;
        cap_ok  = e_q.okx0 && e_q.oky0;
        state_d = B_RD2;
      end
      B_RD2: begin
        addr    = {e_q.y1, e_q.x0, e_q.chan};
        cap_en  = 1'b1;
        cap_idx = 2'd1;
        cap_ok  = e_q.okx1 && e_q.oky0;
        state_d = B_RD3;
      end
      B_RD3: begin
        addr    = {e_q.y1, e_q.x1, e_q.chan};
        cap_en  = 1'b1;
        cap_idx = 2'd2;
        cap_ok  = e_q.okx0 && e_q.oky1;
        state_d = B_CAP;
      end
      B_CAP: begin
        cap_en  = 1'b1;
        cap_idx = 2'd3;
        cap_ok  = e_q.okx1 && e_q.oky1;
        state_d = B_TOP;
      end
      B_TOP: begin
        mix_d   = TW'(p_q[0]) * TW'($signed({1'b0, wx0})) +
                  TW'(p_q[1]) * TW'($signed({1'b0, wx1}));
        state_d = B_BOT;
      end
      B_BOT: begin
        mix_d   = TW'(p_q[2]) * TW'($signed({1'b0, wx0})) +
                  TW'(p_q[3]) * TW'($signed({1'b0, wx1}));
        state_d = B_SUM;
      end
      B_SUM: begin
        sum_d   = SW'(top_q) * SW'($signed({1'b0, wy0})) +
                  SW'(bot_q) * SW'($signed({1'b0, wy1}));
        state_d = B_RND;
      end
      B_RND: begin
        res_valid_d         = 1'b1;
        res_d.channel_error = 1'b0;
        if ((rnd >>> (2 * F)) > V_MAX) begin
          res_d.sample_value = V_MAX[VALUE_BITS-1:0];
        end else if ((rnd >>> (2 * F)) < V_MIN) begin
          res_d.sample_value = V_MIN[VALUE_BITS-1:0];
        end else begin
          res_d.sample_value = VALUE_BITS'(rnd >>> (2 * F));
        end
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= head.wval;
    end
    rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !empty_i) begin
      e_q <= head;
    end
    if (cap_en) begin
      p_q[cap_idx] <= cap;
    end
    if (state_q == B_TOP) top_q <= mix_d;
    if (state_q == B_BOT) bot_q <= mix_d;
    if (state_q == B_SUM) sum_q <= sum_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

// ----- design/bilinear_texel_sampler_top.sv -----
// Bilinear texel sampler: config registers, front end, transaction FIFO and
// back end. Uses btss_pkg, btss_front, btss_fifo, btss_back.
// Sample throughput is set by the front end, which computes the wrap remainder one bit
// per cycle and accepts no new item until the last is pushed; writes skip that step.
// A sample passes the front end, then four single-port memory reads and a blend in the
// top, bottom, sum and round states. Results are strobed for one cycle, no stall.
// Reset clears control state and config to defaults; image memory is not cleared.
module bilinear_texel_sampler_top import btss_pkg::*; #(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int PIXEL_BITS      = PIXEL_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  in_item_t                 item_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output logic                     res_valid_o,
  output out_item_t                res_o
);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW  = 2 + CHW + 2 * XW + 2 * YW + 4 + 2 * COORD_FRAC_BITS + PIXEL_BITS;

  cfg_t          cfg_q;
  logic          push, full, pop, empty;
  logic [EW-1:0] fe_entry, be_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_cols      <= 8'd128;
      cfg_q.img_rows      <= 8'd128;
      cfg_q.channel_count <= 3'd1;
      cfg_q.boundary_mode <= BND_FILL;
      cfg_q.border_val    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:    cfg_q.img_cols      <= cfg_wdata_i[7:0];
        CFG_HEIGHT:   cfg_q.img_rows      <= cfg_wdata_i[7:0];
        CFG_CHANNELS: cfg_q.channel_count <= cfg_wdata_i[2:0];
        CFG_MODE:     cfg_q.boundary_mode <= cfg_wdata_i[1:0];
        CFG_FILL:     cfg_q.border_val    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  btss_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS), .PIXEL_BITS(PIXEL_BITS), .EW(EW)
  ) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i,
    .cfg_i(cfg_q), .push_o(push), .entry_o(fe_entry), .full_i(full)
  );

  btss_fifo #(.W(EW), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(fe_entry), .full_o(full),
    .pop_i(pop), .data_o(be_entry), .empty_o(empty)
  );

  btss_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS), .PIXEL_BITS(PIXEL_BITS), .EW(EW)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .entry_i(be_entry),
    .pop_o(pop), .res_valid_o, .res_o
  );
endmodule
